// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; clock and reset are passed in by the caller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/pcwrl_pkg.sv =====
// shared types and codes of the per-client window rate limiter
// no dependencies
package pcwrl_pkg;

    localparam int ID_W      = 8;
    localparam int TIME_W    = 32;
    localparam int KIND_W    = 2;
    localparam int VERDICT_W = 3;
    localparam int COUNT_W   = 8;
    localparam int WINDOW_W  = 20;
    localparam int COOL_W    = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_CONNECT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DISCONNECT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMMAND    = 2'd2;

    // verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_NONE     = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_ACCEPTED = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_BLOCKED  = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_THROTTLE = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_DROPPED  = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COMMANDS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_MS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_MARGIN  = 2'd3;

    // register reset values
    localparam logic [WINDOW_W-1:0] WINDOW_MS_RST    = 20'd5000;
    localparam logic [COUNT_W-1:0]  MAX_COMMANDS_RST = 8'd10;
    localparam logic [COOL_W-1:0]   COOLDOWN_MS_RST  = 24'd30000;
    localparam logic [COUNT_W-1:0]  WARN_MARGIN_RST  = 8'd2;

    // per-client table entry
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  window_start;
        logic               throttled;
        logic [TIME_W-1:0]  throttle_end;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage

// ===== hdl/pcwrl_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module pcwrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/per_client_window_rate_limiter.sv =====
// per-client fixed-window rate limiter with throttle cooldown
// depends on pcwrl_pkg and pcwrl_ram
//
//  channel   direction  handshake          contents
//  s_*       in         s_tvalid/s_tready  one client event
//  m_*       out        m_tvalid/m_tready  one verdict per event
//  cfg_*     in         cfg_we             register writes
//
// every event is accepted and its table entry read, then modified and written back
// through the single table ram; the next event is taken in the cycle after
// write-back, so no new event is taken while one is being evaluated
// a held result lets one more event in; its write-back and the input wait for m_tready
// rst_n clears the valid bits and the control state and resets the registers at once
module per_client_window_rate_limiter #(
    parameter int NUM_CLIENTS = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [47:0]                     s_tdata,  // client_id, now_ms, empty_command, command_too_long
    input  logic [pcwrl_pkg::KIND_W-1:0]    s_tuser,  // kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,  // verdict, warn_near_limit, cooldown_ended, client_known
    input  logic                            cfg_we,
    input  logic [pcwrl_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [pcwrl_pkg::CFG_W-1:0]     cfg_wdata
);

    import pcwrl_pkg::*;

    localparam int IDX_W = $clog2(NUM_CLIENTS);
    localparam logic [ID_W:0] ID_LIMIT = (ID_W+1)'(NUM_CLIENTS);

    // configuration
    logic [WINDOW_W-1:0] window_ms_reg;
    logic [COUNT_W-1:0]  max_commands_reg;
    logic [COOL_W-1:0]   cooldown_ms_reg;
    logic [COUNT_W-1:0]  warn_margin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ms_reg    <= WINDOW_MS_RST;
            max_commands_reg <= MAX_COMMANDS_RST;
            cooldown_ms_reg  <= COOLDOWN_MS_RST;
            warn_margin_reg  <= WARN_MARGIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_WINDOW_MS:    window_ms_reg    <= cfg_wdata[WINDOW_W-1:0];
                REG_MAX_COMMANDS: max_commands_reg <= cfg_wdata[COUNT_W-1:0];
                REG_COOLDOWN_MS:  cooldown_ms_reg  <= cfg_wdata[COOL_W-1:0];
                REG_WARN_MARGIN:  warn_margin_reg  <= cfg_wdata[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // control and captured event
    state_t                 state_reg, state_next;
    logic [NUM_CLIENTS-1:0] slot_valid_reg, slot_valid_next;
    logic [KIND_W-1:0]      kind_reg;
    logic [ID_W-1:0]        client_id_reg;
    logic [TIME_W-1:0]      now_reg;
    logic                   empty_reg;
    logic                   too_long_reg;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [7:0]             m_tdata_reg, m_tdata_next;

    logic in_xfer;
    logic done;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign done     = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // table ram
    logic             ram_we;
    entry_t           ram_wentry;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t           ent;
    logic [IDX_W-1:0] idx;

    assign idx = client_id_reg[IDX_W-1:0];
    assign ent = entry_t'(ram_rdata);

    pcwrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_CLIENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx),
        .wdata (ram_wentry),
        .re    (in_xfer),
        .raddr (s_tdata[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // event evaluation
    logic                 in_range;
    logic                 known;
    logic [TIME_W-1:0]    since_end;
    logic [TIME_W-1:0]    since_start;
    logic                 expire;
    entry_t               e1;
    entry_t               e2;
    logic [COUNT_W-1:0]   cnt_win;
    logic [COUNT_W-1:0]   cnt_inc;
    logic                 thr_set;
    logic [VERDICT_W-1:0] verdict;
    logic                 warn;
    logic                 ended;

    always_comb
    begin
        in_range    = ({1'b0, client_id_reg} < ID_LIMIT);
        known       = in_range && slot_valid_reg[idx];
        since_end   = now_reg - ent.throttle_end;
        expire      = ent.throttled && !since_end[TIME_W-1];
        verdict     = VERDICT_NONE;
        warn        = 1'b0;
        ended       = 1'b0;
        ram_we      = 1'b0;
        ram_wentry  = '0;
        cnt_win     = '0;
        cnt_inc     = '0;
        thr_set     = 1'b0;
        since_start = '0;

        // first throttle check
        e1 = ent;
        if (expire)
        begin
            e1.throttled    = 1'b0;
            e1.count        = '0;
            e1.window_start = now_reg;
        end

        // window restart, count and throttle
        e2          = e1;
        since_start = now_reg - e1.window_start;
        if (since_start > {{(TIME_W-WINDOW_W){1'b0}}, window_ms_reg})
        begin
            e2.window_start = now_reg;
            cnt_win         = '0;
        end
        else
        begin
            cnt_win = e1.count;
        end
        cnt_inc  = (cnt_win == {COUNT_W{1'b1}}) ? cnt_win : cnt_win + 1'b1;
        e2.count = cnt_inc;
        thr_set  = (cnt_inc > max_commands_reg);
        if (thr_set)
        begin
            e2.throttled    = 1'b1;
            e2.throttle_end = now_reg + {{(TIME_W-COOL_W){1'b0}}, cooldown_ms_reg};
        end
        // the recheck of a fresh throttle only passes with a zero cooldown
        if (thr_set && (cooldown_ms_reg == '0))
        begin
            e2.throttled    = 1'b0;
            e2.count        = '0;
            e2.window_start = now_reg;
        end

        case (kind_reg)
            KIND_CONNECT:
            begin
                ram_we                  = in_range;
                ram_wentry.count        = '0;
                ram_wentry.window_start = now_reg;
                ram_wentry.throttled    = 1'b0;
                ram_wentry.throttle_end = '0;
            end
            KIND_COMMAND:
            begin
                if (known)
                begin
                    ram_we = 1'b1;
                    ended  = expire;
                    if (e1.throttled)
                    begin
                        verdict    = VERDICT_BLOCKED;
                        ram_wentry = e1;
                    end
                    else if (empty_reg)
                    begin
                        ram_wentry = e1;
                    end
                    else
                    begin
                        ram_wentry = e2;
                        warn = (warn_margin_reg <= max_commands_reg) &&
                               (cnt_inc == max_commands_reg - warn_margin_reg);
                        if (thr_set && (cooldown_ms_reg == '0))
                        begin
                            ended = 1'b1;
                        end
                        if (thr_set && (cooldown_ms_reg != '0))
                        begin
                            verdict = VERDICT_THROTTLE;
                        end
                        else if (too_long_reg)
                        begin
                            verdict = VERDICT_DROPPED;
                        end
                        else
                        begin
                            verdict = VERDICT_ACCEPTED;
                        end
                    end
                end
                else if (!empty_reg)
                begin
                    verdict = too_long_reg ? VERDICT_DROPPED : VERDICT_ACCEPTED;
                end
            end
            default:
            begin
            end
        endcase

        ram_we = ram_we && done;
    end

    // next-state logic
    always_comb
    begin
        state_next      = state_reg;
        slot_valid_next = slot_valid_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (done)
                begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, known, ended, warn, verdict};
                    if (in_range && (kind_reg == KIND_CONNECT))
                    begin
                        slot_valid_next[idx] = 1'b1;
                    end
                    if (in_range && (kind_reg == KIND_DISCONNECT))
                    begin
                        slot_valid_next[idx] = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_valid_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        if (in_xfer)
        begin
            kind_reg      <= s_tuser;
            client_id_reg <= s_tdata[ID_W-1:0];
            now_reg       <= s_tdata[ID_W+TIME_W-1:ID_W];
            empty_reg     <= s_tdata[ID_W+TIME_W];
            too_long_reg  <= s_tdata[ID_W+TIME_W+1];
        end
    end

endmodule

// ===== hdl/pcwrl_checker.sv =====
// port-level checks of the rate limiter, bound to the top level
// depends on pcwrl_pkg and assert_macros.svh
`include "assert_macros.svh"

module pcwrl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    import pcwrl_pkg::*;

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
                 m_tvalid && $stable(m_tdata))
    // one event at a time: input closes after a transfer while the event is evaluated
    `ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // verdict code stays in range
    `ASSERT_SAME(a_verdict_range, clk, rst_n, m_tvalid, m_tdata[2:0] <= VERDICT_DROPPED)
    // blocking, warnings and cooldown ends only happen for connected clients
    `ASSERT_SAME(a_state_needs_known, clk, rst_n,
                 m_tvalid && (m_tdata[2:0] == VERDICT_BLOCKED || m_tdata[3] || m_tdata[4]),
                 m_tdata[5])

endmodule

bind per_client_window_rate_limiter pcwrl_checker u_pcwrl_checker (.*);

// ===== tb/sv/tb_top.sv =====
// self-checking bench for per_client_window_rate_limiter: client events in, one verdict out each
// keeps its own copy of the client table to predict verdicts; depends on pcwrl_pkg and the dut
module tb_top;
    import pcwrl_pkg::*;

    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic                 known;
        logic                 ended;
        logic                 warn;
        logic [VERDICT_W-1:0] verdict;
    } verdict_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata = '0;   // client_id, now_ms, empty_command, command_too_long
    logic [KIND_W-1:0]    s_tuser = '0;   // kind
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;        // verdict, warn_near_limit, cooldown_ended, client_known
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // predicted register file
    logic [WINDOW_W-1:0] cfg_window = WINDOW_MS_RST;
    logic [COUNT_W-1:0]  cfg_max    = MAX_COMMANDS_RST;
    logic [COOL_W-1:0]   cfg_cool   = COOLDOWN_MS_RST;
    logic [COUNT_W-1:0]  cfg_margin = WARN_MARGIN_RST;

    // predicted client table
    logic                slot_tbl    [0:255];
    logic [COUNT_W-1:0]  cnt_tbl     [0:255];
    logic [TIME_W-1:0]   win_tbl     [0:255];
    logic                thr_tbl     [0:255];
    logic [TIME_W-1:0]   thr_end_tbl [0:255];

    verdict_t verdict_q [$];

    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_settings = 0;
    int n_warn = 0;
    int n_ended = 0;
    int tally [0:7];
    int cycle_count = 0;
    logic tight = 1'b0;

    per_client_window_rate_limiter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin : table_init
        int i;
        for (i = 0; i < 256; i++)
        begin
            slot_tbl[i]    = 1'b0;
            cnt_tbl[i]     = '0;
            win_tbl[i]     = '0;
            thr_tbl[i]     = 1'b0;
            thr_end_tbl[i] = '0;
        end
        for (i = 0; i < 8; i++)
            tally[i] = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, verdict_q.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // clears an expired throttle, returns 1 when it did
    function automatic logic lift_throttle(input logic [7:0] id, input logic [31:0] now);
        logic [31:0] since;
        since = now - thr_end_tbl[id];
        if (thr_tbl[id] && !since[31])
        begin
            thr_tbl[id] = 1'b0;
            cnt_tbl[id] = '0;
            win_tbl[id] = now;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic verdict_t rate_limit_event(input logic [KIND_W-1:0] kind,
                                                  input logic [7:0] id,
                                                  input logic [31:0] now,
                                                  input logic empty,
                                                  input logic too_long);
        verdict_t res;
        logic [31:0] age;
        logic [COUNT_W-1:0] warn_level;
        res = '0;
        res.verdict = VERDICT_NONE;
        res.known = slot_tbl[id];
        case (kind)
            KIND_CONNECT:
            begin
                slot_tbl[id]    = 1'b1;
                cnt_tbl[id]     = '0;
                win_tbl[id]     = now;
                thr_tbl[id]     = 1'b0;
                thr_end_tbl[id] = '0;
            end
            KIND_DISCONNECT:
            begin
                slot_tbl[id] = 1'b0;
            end
            KIND_COMMAND:
            begin
                if (res.known && lift_throttle(id, now))
                    res.ended = 1'b1;
                if (res.known && thr_tbl[id])
                    res.verdict = VERDICT_BLOCKED;
                else if (empty)
                    res.verdict = VERDICT_NONE;
                else
                begin
                    if (res.known)
                    begin
                        age = now - win_tbl[id];
                        if (age > {12'd0, cfg_window})
                        begin
                            cnt_tbl[id] = '0;
                            win_tbl[id] = now;
                        end
                        if (cnt_tbl[id] != 8'hFF)
                            cnt_tbl[id] = cnt_tbl[id] + 8'd1;
                        warn_level = cfg_max - cfg_margin;
                        if (cfg_margin <= cfg_max && cnt_tbl[id] == warn_level)
                            res.warn = 1'b1;
                        if (cnt_tbl[id] > cfg_max)
                        begin
                            thr_tbl[id]     = 1'b1;
                            thr_end_tbl[id] = now + {8'd0, cfg_cool};
                        end
                        // a zero cooldown ends right here
                        if (lift_throttle(id, now))
                            res.ended = 1'b1;
                    end
                    if (res.known && thr_tbl[id])
                        res.verdict = VERDICT_THROTTLE;
                    else if (too_long)
                        res.verdict = VERDICT_DROPPED;
                    else
                        res.verdict = VERDICT_ACCEPTED;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input verdict_t exp_v, input verdict_t got);
        errors++;
        if (errors <= REPORT_MAX)
        begin
            $display("mismatch (%s) at result %0d: expected verdict %0d warn %0b ended %0b known %0b",
                     what, n_checked, exp_v.verdict, exp_v.warn, exp_v.ended, exp_v.known);
            $display("    got verdict %0d warn %0b ended %0b known %0b",
                     got.verdict, got.warn, got.ended, got.known);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : result_check
        verdict_t got;
        verdict_t exp_v;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.verdict = m_tdata[2:0];
            got.warn    = m_tdata[3];
            got.ended   = m_tdata[4];
            got.known   = m_tdata[5];
            tally[got.verdict] = tally[got.verdict] + 1;
            if (got.warn)
                n_warn++;
            if (got.ended)
                n_ended++;
            if (verdict_q.size() == 0)
            begin
                exp_v = '0;
                report_mismatch("no result expected", exp_v, got);
            end
            else
            begin
                exp_v = verdict_q.pop_front();
                if (got.verdict !== exp_v.verdict || got.warn !== exp_v.warn ||
                    got.ended !== exp_v.ended || got.known !== exp_v.known)
                    report_mismatch("field", exp_v, got);
            end
            n_checked++;
        end
    end

    // receiver back-pressure: short and long stalls, with stretches of none
    initial
    begin : ready_driver
        int r;
        int len;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                m_tready <= 1'b1;
                len = $urandom_range(50, 150);
            end
            else if (r < 60)
            begin
                m_tready <= 1'b1;
                len = $urandom_range(1, 4);
            end
            else if (r < 96)
            begin
                m_tready <= 1'b0;
                len = $urandom_range(1, 3);
            end
            else
            begin
                m_tready <= 1'b0;
                len = $urandom_range(15, 40);
            end
            repeat (len) @(posedge clk);
        end
    end

    task automatic send_event(input logic [KIND_W-1:0] kind, input logic [7:0] id,
                              input logic [31:0] now, input logic empty,
                              input logic too_long);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (tight || r < 55)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 40);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, too_long, empty, now, id};
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        // transfer taken at this edge
        verdict_q.push_back(rate_limit_event(kind, id, now, empty, too_long));
        n_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (verdict_q.size() != 0);
    endtask

    task automatic apply_settings(input logic [WINDOW_W-1:0] w, input logic [COUNT_W-1:0] mx,
                                  input logic [COOL_W-1:0] cl, input logic [COUNT_W-1:0] mg);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_WINDOW_MS;
        cfg_wdata <= {4'd0, w};
        @(posedge clk);
        cfg_addr  <= REG_MAX_COMMANDS;
        cfg_wdata <= {16'd0, mx};
        @(posedge clk);
        cfg_addr  <= REG_COOLDOWN_MS;
        cfg_wdata <= cl;
        @(posedge clk);
        cfg_addr  <= REG_WARN_MARGIN;
        cfg_wdata <= {16'd0, mg};
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_window = w;
        cfg_max    = mx;
        cfg_cool   = cl;
        cfg_margin = mg;
        n_settings++;
    endtask

    // reset values: unknown clients, connect, empty and long commands, reserved kind, disconnect
    task automatic test_defaults();
        send_event(KIND_COMMAND, 8'd7, 32'd0, 1'b0, 1'b0);
        send_event(KIND_COMMAND, 8'd7, 32'd1, 1'b1, 1'b0);
        send_event(KIND_COMMAND, 8'd7, 32'd2, 1'b0, 1'b1);
        send_event(KIND_CONNECT, 8'd255, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_event(KIND_COMMAND, 8'd255, 32'hFFFF_FFFF, 1'b0, 1'b0);
        // empty wins over too long and is not counted
        send_event(KIND_COMMAND, 8'd255, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_event(KIND_COMMAND, 8'd255, 32'd0, 1'b0, 1'b1);
        send_event(KIND_RESERVED, 8'd255, 32'd0, 1'b1, 1'b1);
        send_event(KIND_DISCONNECT, 8'd255, 32'd0, 1'b0, 1'b0);
        send_event(KIND_COMMAND, 8'd255, 32'd1, 1'b0, 1'b0);
    endtask

    // limit of one, throttle, block, cooldown end exactly at its end time, window restart
    task automatic test_throttle_cycle();
        apply_settings(20'd1000000, 8'd1, 24'd10, 8'd0);
        send_event(KIND_CONNECT, 8'd0, 32'd100, 1'b0, 1'b0);
        send_event(KIND_COMMAND, 8'd0, 32'd100, 1'b0, 1'b0);
        // throttled now beats too long
        send_event(KIND_COMMAND, 8'd0, 32'd101, 1'b0, 1'b1);
        send_event(KIND_COMMAND, 8'd0, 32'd110, 1'b0, 1'b0);
        send_event(KIND_COMMAND, 8'd0, 32'd110, 1'b1, 1'b0);
        send_event(KIND_COMMAND, 8'd0, 32'd111, 1'b0, 1'b0);
        send_event(KIND_COMMAND, 8'd0, 32'd111 + 32'd1000001, 1'b0, 1'b0);
    endtask

    // zero cooldown, one ms window, margin above the limit
    task automatic test_cooldown_zero();
        apply_settings(20'd1, 8'd1, 24'd0, 8'd253);
        send_event(KIND_CONNECT, 8'd9, 32'd50, 1'b0, 1'b0);
        send_event(KIND_COMMAND, 8'd9, 32'd50, 1'b0, 1'b0);
        send_event(KIND_COMMAND, 8'd9, 32'd51, 1'b0, 1'b1);
        send_event(KIND_COMMAND, 8'd9, 32'd53, 1'b0, 1'b0);
    endtask

    // count stops at 255 when the limit can never be exceeded
    task automatic test_count_saturation();
        int i;
        apply_settings(20'd1000000, 8'd255, 24'd1, 8'd0);
        send_event(KIND_CONNECT, 8'd128, 32'h8000_0000, 1'b0, 1'b0);
        for (i = 0; i < 258; i++)
            send_event(KIND_COMMAND, 8'd128, 32'h8000_0000, 1'b0, i[0]);
    endtask

    task automatic run_phase(input int n, input logic [WINDOW_W-1:0] w,
                             input logic [COUNT_W-1:0] mx, input logic [COOL_W-1:0] cl,
                             input logic [COUNT_W-1:0] mg, input int unsigned tick);
        logic [7:0] pool [0:7];
        int pool_n;
        int i;
        int r;
        int pick;
        logic [31:0] now;
        logic e;
        logic tl;
        apply_settings(w, mx, cl, mg);
        pool_n = $urandom_range(3, 6);
        for (i = 0; i < pool_n; i++)
            pool[i] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 2) == 0)
            now = 32'hFFFF_FFFF - $urandom_range(0, 500);
        else
            now = $urandom;
        for (i = 0; i < pool_n; i++)
            send_event(KIND_CONNECT, pool[i], now, 1'b0, 1'b0);
        for (i = 0; i < n; i++)
        begin
            if (i % 50 == 0)
                tight = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) == 0)
                wait_for_results();
            if ($urandom_range(0, 99) < 2)
                now = $urandom;
            else
                now = now + $urandom_range(0, tick);
            pick = $urandom_range(0, pool_n - 1);
            e  = ($urandom_range(0, 11) == 0);
            tl = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 99);
            if (r < 78)
                send_event(KIND_COMMAND, pool[pick], now, e, tl);
            else if (r < 82)
                send_event(KIND_CONNECT, pool[pick], now, e, tl);
            else if (r < 86)
                send_event(KIND_DISCONNECT, pool[pick], now, e, tl);
            else if (r < 91)
                send_event(KIND_COMMAND, 8'($urandom_range(0, 255)), now,
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if (r < 94)
                send_event(KIND_RESERVED, pool[pick], now,
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if (r < 97)
                send_event(KIND_CONNECT, 8'($urandom_range(0, 255)), now, e, tl);
            else
                send_event(KIND_DISCONNECT, 8'($urandom_range(0, 255)), now, e, tl);
        end
        tight = 1'b0;
    endtask

    task automatic test_random_traffic();
        int p;
        logic [WINDOW_W-1:0] w;
        logic [COUNT_W-1:0] mx;
        run_phase(215, 20'd5000, 8'd10, 24'd30000, 8'd2, 800);
        run_phase(215, 20'd1000000, 8'd254, 24'd10000000, 8'd253, 200000);
        run_phase(215, 20'd1, 8'd1, 24'd1, 8'd0, 2);
        for (p = 0; p < 4; p++)
        begin
            w  = WINDOW_W'($urandom_range(4, 200));
            mx = COUNT_W'($urandom_range(1, 8));
            run_phase(215, w, mx, COOL_W'($urandom_range(1, 300)),
                      COUNT_W'($urandom_range(0, mx + 1)), w / 3 + 1);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_throttle_cycle();
        test_cooldown_zero();
        test_count_saturation();
        test_random_traffic();
        wait_for_results();
        repeat (10) @(posedge clk);
        $display("covered %0d events under %0d register settings, %0d results checked",
                 n_sent, n_settings, n_checked);
        $display("accepted %0d blocked %0d throttled %0d dropped %0d none %0d warn %0d ends %0d",
                 tally[VERDICT_ACCEPTED], tally[VERDICT_BLOCKED], tally[VERDICT_THROTTLE],
                 tally[VERDICT_DROPPED], tally[VERDICT_NONE], n_warn, n_ended);
        if (errors == 0 && verdict_q.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
